### design/wsp_pkg.sv
// wsp_pkg: shared types and constants of the wav stream parser
// used by wsp_front, wsp_fifo, wsp_back and the top level
`timescale 1ns / 1ps

package wsp_pkg;

  // result kinds
  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_FORMAT = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // error codes
  localparam logic ERR_NOT_WAVE = 1'b0;
  localparam logic ERR_FORMAT   = 1'b1;

  // configuration register indexes
  localparam logic REG_CLOCK_HZ    = 1'b0;
  localparam logic REG_PLAY_ENABLE = 1'b1;

  localparam int unsigned CLK_W   = 27;
  localparam int unsigned PRE_W   = 20;
  localparam int unsigned RATE_W  = 16;
  localparam logic [CLK_W-1:0] CLOCK_HZ_RST = 27'd32000000;

  // command passed from the parser to the output side
  typedef struct packed {
    logic [1:0]        kind;
    logic [7:0]        sample;
    logic [1:0]        channels;
    logic [4:0]        bits;
    logic [RATE_W-1:0] rate;
    logic              err;
    logic              last;
  } cmd_t;

endpackage

### design/wsp_front.sv
// wsp_front: byte-wise RIFF/WAVE parser, one file byte per transfer
// depends on wsp_pkg; issues commands toward the queue
`timescale 1ns / 1ps

module wsp_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_ready_i,
  input  logic [7:0]      file_byte_i,
  input  logic            new_file_i,
  input  logic            play_en_i,
  output logic            push_o,
  output wsp_pkg::cmd_t   cmd_o
);

  localparam logic [3:0] PH_RIFF      = 4'd0;
  localparam logic [3:0] PH_RIFF_BAD  = 4'd1;
  localparam logic [3:0] PH_FMT_HDR   = 4'd2;
  localparam logic [3:0] PH_FMT_SKIP  = 4'd3;
  localparam logic [3:0] PH_FMT_BODY  = 4'd4;
  localparam logic [3:0] PH_FMT_EXTRA = 4'd5;
  localparam logic [3:0] PH_DATA_HDR  = 4'd6;
  localparam logic [3:0] PH_DATA_SKIP = 4'd7;
  localparam logic [3:0] PH_PLAY      = 4'd8;
  localparam logic [3:0] PH_DONE      = 4'd9;

  localparam logic [31:0] TAG_RIFF = 32'h52494646;
  localparam logic [31:0] TAG_WAVE = 32'h57415645;
  localparam logic [31:0] TAG_FMT  = 32'h666D7420;
  localparam logic [31:0] TAG_DATA = 32'h64617461;

  logic [3:0]  phase_q, phase_d;
  logic [4:0]  idx_q, idx_d;
  logic [31:0] tag_q, tag_d;
  logic [31:0] len_q, len_d;
  logic [31:0] skip_q, skip_d;
  logic [15:0] fmt_q, fmt_d;
  logic [15:0] chan_q, chan_d;
  logic [31:0] rate_q, rate_d;
  logic [15:0] bits_q, bits_d;
  logic [31:0] rem_q, rem_d;
  logic [7:0]  lo_q, lo_d;
  logic [7:0]  left_q, left_d;
  logic [1:0]  fb_q, fb_d;

  logic        accept;
  assign accept = in_valid_i && in_ready_i;

  // parse one byte
  always_comb begin
    logic       hdr_done;
    logic       fmt_ok;
    logic       two_b;
    logic       stereo;
    logic [2:0] fsize;
    logic [2:0] fb_nxt;
    logic       ch;
    logic [7:0] cv;
    logic [8:0] sum;
    logic       chan_done;
    logic [7:0] b;
    phase_d = phase_q; idx_d = idx_q; tag_d = tag_q; len_d = len_q;
    skip_d = skip_q; fmt_d = fmt_q; chan_d = chan_q; rate_d = rate_q;
    bits_d = bits_q; rem_d = rem_q; lo_d = lo_q; left_d = left_q; fb_d = fb_q;
    push_o = 1'b0;
    cmd_o = '0;
    hdr_done = 1'b0;
    b = file_byte_i;
    two_b = 1'b0; stereo = 1'b0; fsize = 3'd1; fb_nxt = 3'd0; ch = 1'b0;
    cv = 8'd0; sum = 9'd0; chan_done = 1'b1; fmt_ok = 1'b0;

    // start of a new file restarts the parse
    if (new_file_i) begin
      phase_d = PH_RIFF; idx_d = '0; tag_d = '0; len_d = '0; skip_d = '0;
      fmt_d = '0; chan_d = '0; rate_d = '0; bits_d = '0; rem_d = '0;
      lo_d = '0; left_d = '0; fb_d = '0;
    end

    // shared chunk header collection
    if (phase_d == PH_FMT_HDR || phase_d == PH_DATA_HDR) begin
      if (idx_d == 5'd0) len_d = '0;
      if (idx_d < 5'd4) begin
        tag_d = {tag_d[23:0], b};
      end else begin
        case (idx_d[1:0])
          2'd0:    len_d[7:0]   = b;
          2'd1:    len_d[15:8]  = b;
          2'd2:    len_d[23:16] = b;
          default: len_d[31:24] = b;
        endcase
      end
      idx_d = idx_d + 5'd1;
      if (idx_d >= 5'd8) begin
        idx_d = '0;
        hdr_done = 1'b1;
      end
    end

    case (phase_d)
      PH_RIFF, PH_RIFF_BAD: begin
        tag_d = {tag_d[23:0], b};
        if (idx_d == 5'd3 && tag_d != TAG_RIFF) phase_d = PH_RIFF_BAD;
        if (idx_d >= 5'd11) begin
          idx_d = '0;
          if (phase_d == PH_RIFF && tag_d == TAG_WAVE) begin
            phase_d = PH_FMT_HDR;
          end else begin
            phase_d = PH_DONE;
            push_o = 1'b1;
            cmd_o.kind = wsp_pkg::KIND_ERROR;
            cmd_o.err = wsp_pkg::ERR_NOT_WAVE;
          end
        end else begin
          idx_d = idx_d + 5'd1;
        end
      end
      PH_FMT_HDR: begin
        if (hdr_done) begin
          if (tag_d == TAG_FMT) begin
            skip_d = (len_d > 32'd16) ? len_d - 32'd16 : 32'd0;
            fmt_d = '0; chan_d = '0; rate_d = '0; bits_d = '0;
            phase_d = PH_FMT_BODY;
          end else if (len_d != 32'd0) begin
            skip_d = len_d;
            phase_d = PH_FMT_SKIP;
          end
        end
      end
      PH_FMT_SKIP, PH_FMT_EXTRA, PH_DATA_SKIP: begin
        skip_d = skip_d - 32'd1;
        if (skip_d == 32'd0)
          phase_d = (phase_d == PH_FMT_SKIP) ? PH_FMT_HDR : PH_DATA_HDR;
      end
      PH_FMT_BODY: begin
        case (idx_d)
          5'd0:    fmt_d[7:0]    = b;
          5'd1:    fmt_d[15:8]   = b;
          5'd2:    chan_d[7:0]   = b;
          5'd3:    chan_d[15:8]  = b;
          5'd4:    rate_d[7:0]   = b;
          5'd5:    rate_d[15:8]  = b;
          5'd6:    rate_d[23:16] = b;
          5'd7:    rate_d[31:24] = b;
          5'd14:   bits_d[7:0]   = b;
          5'd15:   bits_d[15:8]  = b;
          default: ;
        endcase
        idx_d = idx_d + 5'd1;
        if (idx_d >= 5'd16) begin
          idx_d = '0;
          phase_d = (skip_d != 32'd0) ? PH_FMT_EXTRA : PH_DATA_HDR;
        end
      end
      PH_DATA_HDR: begin
        if (hdr_done) begin
          if (tag_d != TAG_DATA) begin
            if (len_d != 32'd0) begin
              skip_d = len_d;
              phase_d = PH_DATA_SKIP;
            end
          end else begin
            rem_d = len_d;
            fb_d = '0;
            fmt_ok = (fmt_d == 16'd1) && (chan_d == 16'd1 || chan_d == 16'd2) &&
                     (bits_d == 16'd8 || bits_d == 16'd16) &&
                     rate_d >= 32'd100 && rate_d <= 32'd44200 && rem_d != 32'd0;
            push_o = 1'b1;
            if (!fmt_ok) begin
              phase_d = PH_DONE;
              cmd_o.kind = wsp_pkg::KIND_ERROR;
              cmd_o.err = wsp_pkg::ERR_FORMAT;
            end else begin
              phase_d = play_en_i ? PH_PLAY : PH_DONE;
              cmd_o.kind = wsp_pkg::KIND_FORMAT;
              cmd_o.channels = chan_d[1:0];
              cmd_o.bits = bits_d[4:0];
              cmd_o.rate = rate_d[15:0];
            end
          end
        end
      end
      PH_PLAY: begin
        two_b = (bits_d == 16'd16);
        stereo = (chan_d == 16'd2);
        fsize = 3'd1 << ({1'b0, two_b} + {1'b0, stereo});
        ch = two_b ? fb_d[1] : fb_d[0];
        cv = b;
        rem_d = rem_d - 32'd1;
        if (two_b) begin
          if (!fb_d[0]) begin
            lo_d = b;
            chan_done = 1'b0;
          end else begin
            // signed word / 256 toward zero, then offset to unsigned
            cv = {~b[7], b[6:0]} + {7'd0, (b[7] && lo_d != 8'd0)};
          end
        end
        if (chan_done) begin
          if (!stereo) begin
            push_o = 1'b1;
            cmd_o.sample = cv;
          end else if (!ch) begin
            left_d = cv;
          end else begin
            sum = {1'b0, left_d} + {1'b0, cv};
            push_o = 1'b1;
            cmd_o.sample = sum[8:1];
          end
        end
        cmd_o.kind = wsp_pkg::KIND_SAMPLE;
        fb_nxt = {1'b0, fb_d} + 3'd1;
        fb_d = (fb_nxt >= fsize) ? 2'd0 : fb_nxt[1:0];
        cmd_o.last = (rem_d < {29'd0, fsize});
        if (rem_d == 32'd0) phase_d = PH_DONE;
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_RIFF;
      idx_q   <= '0;
      fb_q    <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      fb_q    <= fb_d;
    end
  end

  // parse payload state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0; len_q <= '0; skip_q <= '0; fmt_q <= '0; chan_q <= '0;
      rate_q <= '0; bits_q <= '0; rem_q <= '0; lo_q <= '0; left_q <= '0;
    end else if (accept) begin
      tag_q <= tag_d; len_q <= len_d; skip_q <= skip_d; fmt_q <= fmt_d;
      chan_q <= chan_d; rate_q <= rate_d; bits_q <= bits_d; rem_q <= rem_d;
      lo_q <= lo_d; left_q <= left_d;
    end
  end

endmodule

### design/wsp_fifo.sv
// wsp_fifo: two-entry command queue between parser and output side
// depends on wsp_pkg for the command type
`timescale 1ns / 1ps

module wsp_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  wsp_pkg::cmd_t wdata_i,
  input  logic          pop_i,
  output wsp_pkg::cmd_t rdata_o,
  output logic          full_o,
  output logic          empty_o
);

  wsp_pkg::cmd_t mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign rdata_o = mem_q[rptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= wdata_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

### design/wsp_back.sv
// wsp_back: drains commands, runs the prescaler division, holds the result
// depends on wsp_pkg; the divider is serial, one quotient bit per cycle
`timescale 1ns / 1ps

module wsp_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [wsp_pkg::CLK_W-1:0] clock_hz_i,
  input  wsp_pkg::cmd_t            cmd_i,
  input  logic                     empty_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output wsp_pkg::cmd_t            res_o,
  output logic [wsp_pkg::PRE_W-1:0] prescaler_o
);

  localparam logic [1:0] BS_IDLE = 2'd0;
  localparam logic [1:0] BS_DIV  = 2'd1;
  localparam logic [1:0] BS_SEND = 2'd2;

  logic [1:0]                   state_q, state_d;
  logic [4:0]                   cnt_q;
  logic [wsp_pkg::CLK_W-1:0]    quo_q;
  logic [wsp_pkg::RATE_W-1:0]   rem_q;
  wsp_pkg::cmd_t                hold_q;
  logic                         ov_q;
  wsp_pkg::cmd_t                res_q;
  logic [wsp_pkg::PRE_W-1:0]    pre_q;

  logic                         slot_free;
  logic [wsp_pkg::RATE_W:0]     shifted;
  logic [wsp_pkg::RATE_W:0]     trial;
  logic                         ge;

  assign slot_free   = !ov_q || out_ready_i;
  assign out_valid_o = ov_q;
  assign res_o       = res_q;
  assign prescaler_o = pre_q;

  // one restoring division step
  assign shifted = {rem_q, quo_q[wsp_pkg::CLK_W-1]};
  assign trial   = shifted - {1'b0, hold_q.rate};
  assign ge      = (shifted >= {1'b0, hold_q.rate});

  assign pop_o = (state_q == BS_IDLE) && !empty_i && slot_free;

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      BS_IDLE: if (pop_o && cmd_i.kind == wsp_pkg::KIND_FORMAT) state_d = BS_DIV;
      BS_DIV:  if (cnt_q == 5'd1) state_d = BS_SEND;
      BS_SEND: if (slot_free) state_d = BS_IDLE;
      default: state_d = BS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BS_IDLE;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop_o) cnt_q <= 5'(wsp_pkg::CLK_W);
      else if (state_q == BS_DIV) cnt_q <= cnt_q - 5'd1;
      if (pop_o && cmd_i.kind != wsp_pkg::KIND_FORMAT) ov_q <= 1'b1;
      else if (state_q == BS_SEND && slot_free) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  // divider datapath and output register
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      hold_q <= cmd_i;
      quo_q  <= clock_hz_i;
      rem_q  <= '0;
      if (cmd_i.kind != wsp_pkg::KIND_FORMAT) begin
        res_q <= cmd_i;
        pre_q <= '0;
      end
    end else if (state_q == BS_DIV) begin
      rem_q <= ge ? trial[wsp_pkg::RATE_W-1:0] : shifted[wsp_pkg::RATE_W-1:0];
      quo_q <= {quo_q[wsp_pkg::CLK_W-2:0], ge};
    end else if (state_q == BS_SEND && slot_free) begin
      res_q <= hold_q;
      pre_q <= (|quo_q[wsp_pkg::CLK_W-1:wsp_pkg::PRE_W]) ? '1 :
               quo_q[wsp_pkg::PRE_W-1:0];
    end
  end

  a_pre_only_format: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && res_q.kind != wsp_pkg::KIND_FORMAT |-> pre_q == '0)
    else $error("prescaler set on a non-format result");
  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> res_q.kind != 2'd3)
    else $error("illegal result kind");
  a_div_rate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BS_DIV |-> hold_q.rate >= 16'd100)
    else $error("division started with an unchecked rate");
  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != BS_IDLE |-> !pop_o)
    else $error("queue drained while divider busy");

endmodule

### design/wav_stream_to_pcm8_mono.sv
// wav_stream_to_pcm8_mono: top level of the WAV byte stream parser
// depends on wsp_pkg, wsp_front, wsp_fifo and wsp_back
`timescale 1ns / 1ps

// Takes a WAV file one byte per transfer and returns format, error and
// 8-bit mono sample results. Bytes are taken one per cycle while the
// two-entry command queue has room; the parser itself never stalls. A
// format result goes through the 27-step serial divider in the output
// side that forms clock_hz / rate, so the queue can fill and the byte
// input pause while the divider runs, once per file. Samples and errors
// skip the divider and go straight to the output register. Configuration
// registers: index 0 clock_hz, index 1 play_enable.
module wav_stream_to_pcm8_mono (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [26:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  file_byte_i,
  input  logic        new_file_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  sample_o,
  output logic [1:0]  channels_o,
  output logic [4:0]  bits_per_sample_o,
  output logic [15:0] sample_rate_o,
  output logic [19:0] prescaler_o,
  output logic        error_code_o,
  output logic        last_o
);

  logic [wsp_pkg::CLK_W-1:0] clock_hz_q;
  logic                      play_en_q;
  logic                      push, pop, full, empty;
  wsp_pkg::cmd_t             cmd_w, cmd_r, res;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_hz_q <= wsp_pkg::CLOCK_HZ_RST;
      play_en_q  <= 1'b1;
    end else if (cfg_we_i) begin
      if (cfg_index_i == wsp_pkg::REG_CLOCK_HZ)    clock_hz_q <= cfg_data_i;
      if (cfg_index_i == wsp_pkg::REG_PLAY_ENABLE) play_en_q  <= cfg_data_i[0];
    end
  end

  assign in_ready_o = !full;

  wsp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .file_byte_i (file_byte_i),
    .new_file_i  (new_file_i),
    .play_en_i   (play_en_q),
    .push_o      (push),
    .cmd_o       (cmd_w)
  );

  wsp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push && in_valid_i && in_ready_o),
    .wdata_i (cmd_w),
    .pop_i   (pop),
    .rdata_o (cmd_r),
    .full_o  (full),
    .empty_o (empty)
  );

  wsp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clock_hz_i  (clock_hz_q),
    .cmd_i       (cmd_r),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res),
    .prescaler_o (prescaler_o)
  );

  // result fields
  assign kind_o            = res.kind;
  assign sample_o          = res.sample;
  assign channels_o        = res.channels;
  assign bits_per_sample_o = res.bits;
  assign sample_rate_o     = res.rate;
  assign error_code_o      = res.err;
  assign last_o            = res.last;

endmodule
